### src/humidity_relay_controller_top_defines.svh
// ---------------------------------------------------------------------------
// humidity_relay_controller_top_defines
// Assertion macros shared by the humidity relay controller RTL.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_RELAY_CONTROLLER_TOP_DEFINES_SVH
`define HUMIDITY_RELAY_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrc assertion failed");

// Next-cycle implication, disabled while in reset.
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrc assertion failed");

`endif

### src/hrc_pkg.sv
// ---------------------------------------------------------------------------
// hrc_pkg
// Types and constants for the humidity relay controller.
// ---------------------------------------------------------------------------
package hrc_pkg;

	localparam int unsigned HUM_W    = 10;
	localparam int unsigned SEC_W    = 16;
	localparam int unsigned TIME_W   = 32;
	// seconds * 1000 fits in 26 bits (65535000 < 2^26)
	localparam int unsigned MS_W     = 26;
	localparam int unsigned MS_PER_S = 1000;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned CFGD_W   = 16;
	localparam int unsigned IN_W     = 64;
	localparam int unsigned OUT_W    = 16;

	typedef enum logic [1:0] {
		MODE_HUMIDITY = 2'd0,
		MODE_NIGHT    = 2'd1,
		MODE_OVR_ON   = 2'd2,
		MODE_OVR_OFF  = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_HUM_FLOOR   = 3'd0,
		REG_ASST_FLOOR  = 3'd1,
		REG_HUM_CEIL    = 3'd2,
		REG_BURST_ON    = 3'd3,
		REG_BURST_OFF   = 3'd4,
		REG_OVR_TIMEOUT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [HUM_W-1:0] hum_floor;
		logic [HUM_W-1:0] asst_floor;
		logic [HUM_W-1:0] hum_ceil;
		logic [MS_W-1:0]  burst_on_ms;
		logic [MS_W-1:0]  burst_off_ms;
		logic [MS_W-1:0]  ovr_timeout_ms;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [TIME_W-1:0] now_ms;
		logic [HUM_W-1:0]  humidity;
		logic              humidity_valid;
		logic [HUM_W-1:0]  last_good_humidity;
		logic              calibration_active;
		logic              night_now;
		logic              humidifier_on;
		logic              assist_on;
		logic              compressor_on;
	} item_t;

	typedef struct packed {
		logic humidifier_write;
		logic humidifier_value;
		logic assist_write;
		logic assist_value;
		logic compressor_force_off;
		logic burst_running;
		logic burst_in_on_phase;
		logic override_running;
		logic night_lockout;
	} result_t;

	function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
		sec_to_ms = MS_W'(sec) * MS_W'(MS_PER_S);
	endfunction

endpackage

### src/hrc_step.sv
// ---------------------------------------------------------------------------
// hrc_step
// Control state and one-event decision logic; state commits on advance.
// ---------------------------------------------------------------------------
module hrc_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  hrc_pkg::item_t  item,
	input  hrc_pkg::cfg_t   cfg,
	output hrc_pkg::result_t result
);
	import hrc_pkg::*;

	logic              night_q, burst_q, phase_q, ovr_q;
	logic [TIME_W-1:0] phase_start_q, ovr_start_q;

	logic              night_d, burst_d, phase_d, ovr_d;
	logic [TIME_W-1:0] phase_start_d, ovr_start_d;

	logic              ovr_expired, ovr_live;
	logic [HUM_W-1:0]  hum;
	logic              phase_eff;
	logic [TIME_W-1:0] start_eff, ovr_elapsed, burst_elapsed;
	logic [MS_W-1:0]   burst_thr;
	logic              burst_expired;
	logic hw, hv, aw, av, cfo;

	assign ovr_elapsed   = item.now_ms - ovr_start_q;
	assign ovr_expired   = ovr_elapsed >= TIME_W'(cfg.ovr_timeout_ms);
	assign ovr_live      = ovr_q && !ovr_expired;
	assign hum           = item.humidity_valid ? item.humidity : item.last_good_humidity;

	// a fresh burst starts in its on phase at this time stamp
	assign phase_eff     = burst_q ? phase_q : 1'b1;
	assign start_eff     = burst_q ? phase_start_q : item.now_ms;
	assign burst_elapsed = item.now_ms - start_eff;
	assign burst_thr     = phase_eff ? cfg.burst_on_ms : cfg.burst_off_ms;
	assign burst_expired = burst_elapsed >= TIME_W'(burst_thr);

	always_comb begin
		night_d       = night_q;
		burst_d       = burst_q;
		phase_d       = phase_q;
		phase_start_d = phase_start_q;
		ovr_d         = ovr_q;
		ovr_start_d   = ovr_start_q;
		hw  = 1'b0;
		hv  = 1'b0;
		aw  = 1'b0;
		av  = 1'b0;
		cfo = 1'b0;
		case (item.mode)
			MODE_HUMIDITY: begin
				if (!item.calibration_active) begin
					ovr_d = ovr_live;
					if (!ovr_live) begin
						if (hum >= cfg.hum_ceil) begin
							hw = item.humidifier_on;
							if (burst_q || item.assist_on) begin
								aw      = 1'b1;
								burst_d = 1'b0;
								phase_d = 1'b0;
							end
						end else begin
							if (hum < cfg.hum_floor) begin
								if (!item.humidifier_on) begin
									hw = 1'b1;
									hv = 1'b1;
								end
							end else begin
								hw = item.humidifier_on;
							end
							if (hum < cfg.asst_floor) begin
								burst_d = 1'b1;
								if (burst_expired) begin
									phase_d       = !phase_eff;
									phase_start_d = item.now_ms;
									aw            = 1'b1;
									av            = !phase_eff;
								end else begin
									phase_d       = phase_eff;
									phase_start_d = start_eff;
									aw            = !burst_q;
									av            = !burst_q;
								end
							end else if (burst_q) begin
								burst_d = 1'b0;
								phase_d = 1'b0;
								aw      = 1'b1;
							end
						end
					end
				end
			end
			MODE_NIGHT: begin
				night_d = item.night_now;
				if (item.night_now) begin
					cfo = item.compressor_on;
					if (item.assist_on) begin
						aw      = 1'b1;
						burst_d = 1'b0;
						phase_d = 1'b0;
					end
				end
			end
			MODE_OVR_ON: begin
				ovr_d       = 1'b1;
				ovr_start_d = item.now_ms;
			end
			MODE_OVR_OFF: begin
				ovr_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.humidifier_write     = hw;
		result.humidifier_value     = hv;
		result.assist_write         = aw;
		result.assist_value         = av;
		result.compressor_force_off = cfo;
		result.burst_running        = burst_d;
		result.burst_in_on_phase    = phase_d;
		result.override_running     = ovr_d;
		result.night_lockout        = night_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q       <= 1'b0;
			burst_q       <= 1'b0;
			phase_q       <= 1'b0;
			phase_start_q <= '0;
			ovr_q         <= 1'b0;
			ovr_start_q   <= '0;
		end else if (advance) begin
			night_q       <= night_d;
			burst_q       <= burst_d;
			phase_q       <= phase_d;
			phase_start_q <= phase_start_d;
			ovr_q         <= ovr_d;
			ovr_start_q   <= ovr_start_d;
		end
	end

endmodule

### src/humidity_relay_controller_top.sv
// Each beat passes through the input register and then the result register on its way out.
// Throughput: one event per cycle; the relay state update is a single compare/subtract
// pass between the input register and the result register.
// Stalls: a full result register holds the input register, which then drops s_axis_tready.
// Reset (arst_n low, async): thresholds return to defaults, relay/burst/override state
// clears, both pipeline registers empty. No clearing pass; first beat accepted at once.
// ---------------------------------------------------------------------------
// humidity_relay_controller_top
// Humidity relay controller: event stream in, relay command beat out.
// ---------------------------------------------------------------------------
`include "humidity_relay_controller_top_defines.svh"

module humidity_relay_controller_top (
	input  logic                      clk,
	input  logic                      arst_n,
	// config write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hrc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [hrc_pkg::CFGD_W-1:0] cfg_data,
	// event stream in
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// now_ms[31:0], humidity[41:32], humidity_valid[42], last_good_humidity[52:43],
	// calibration_active[53], night_now[54], humidifier_on[55], assist_on[56],
	// compressor_on[57], zero[63:58]
	input  logic [hrc_pkg::IN_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]                s_axis_tuser,
	// result stream out
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// humidifier_write[0], humidifier_value[1], assist_write[2], assist_value[3],
	// compressor_force_off[4], burst_running[5], burst_in_on_phase[6],
	// override_running[7], night_lockout[8], zero[15:9]
	output logic [hrc_pkg::OUT_W-1:0]  m_axis_tdata
);
	import hrc_pkg::*;

	cfg_t    cfg_q;
	item_t   item_in, item_s1;
	logic    valid_s1;
	result_t res_d, res_q;
	logic    out_valid_q;
	logic    s_fire, advance;

	// Config: thresholds in ms are formed at write time so the event path
	// only has a subtract and a compare.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hum_floor      <= HUM_W'(600);
			cfg_q.asst_floor     <= HUM_W'(500);
			cfg_q.hum_ceil       <= HUM_W'(800);
			cfg_q.burst_on_ms    <= MS_W'(10 * MS_PER_S);
			cfg_q.burst_off_ms   <= MS_W'(50 * MS_PER_S);
			cfg_q.ovr_timeout_ms <= MS_W'(600 * MS_PER_S);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_HUM_FLOOR:   cfg_q.hum_floor      <= cfg_data[HUM_W-1:0];
				REG_ASST_FLOOR:  cfg_q.asst_floor     <= cfg_data[HUM_W-1:0];
				REG_HUM_CEIL:    cfg_q.hum_ceil       <= cfg_data[HUM_W-1:0];
				REG_BURST_ON:    cfg_q.burst_on_ms    <= sec_to_ms(cfg_data);
				REG_BURST_OFF:   cfg_q.burst_off_ms   <= sec_to_ms(cfg_data);
				REG_OVR_TIMEOUT: cfg_q.ovr_timeout_ms <= sec_to_ms(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Unpack the input beat.
	always_comb begin
		item_in.mode               = mode_t'(s_axis_tuser);
		item_in.now_ms             = s_axis_tdata[31:0];
		item_in.humidity           = s_axis_tdata[41:32];
		item_in.humidity_valid     = s_axis_tdata[42];
		item_in.last_good_humidity = s_axis_tdata[52:43];
		item_in.calibration_active = s_axis_tdata[53];
		item_in.night_now          = s_axis_tdata[54];
		item_in.humidifier_on      = s_axis_tdata[55];
		item_in.assist_on          = s_axis_tdata[56];
		item_in.compressor_on      = s_axis_tdata[57];
	end

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= item_in;
		end
	end

	hrc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.night_lockout, res_q.override_running,
		res_q.burst_in_on_phase, res_q.burst_running, res_q.compressor_force_off,
		res_q.assist_value, res_q.assist_write, res_q.humidifier_value,
		res_q.humidifier_write};

	// A commanded value is never set without its write strobe.
	`HRC_ASSERT_IMPLY(a_value_needs_write, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[1] && !m_axis_tdata[0]) && !(m_axis_tdata[3] && !m_axis_tdata[2]))
	// On phase only exists inside a running burst.
	`HRC_ASSERT_IMPLY(a_phase_in_burst, clk, arst_n, m_axis_tvalid, !m_axis_tdata[6] || m_axis_tdata[5])
	// A held event with a stalled result blocks the input side.
	`HRC_ASSERT_IMPLY(a_stall_blocks, clk, arst_n, valid_s1 && out_valid_q && !m_axis_tready, !s_axis_tready)
	// Every stage-1 advance yields a result beat next cycle.
	`HRC_ASSERT_NEXT(a_advance_result, clk, arst_n, advance, m_axis_tvalid)

endmodule
